// ===== rtl/core/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types, widths and codes of the fixed-priority slack engine.
// ----------------------------------------------------------------------------
package fps_pkg;

   localparam int MAX_TASKS     = 16;
   localparam int TICK_BITS     = 32;
   localparam int IDX_BITS      = $clog2(MAX_TASKS);
   localparam int COUNT_BITS    = $clog2(MAX_TASKS + 1);
   localparam int DIV_CNT_BITS  = $clog2(TICK_BITS);
   localparam int ACT_BITS      = 3;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [TICK_BITS-1:0] tick_type;

   typedef enum logic [ACT_BITS-1:0] {
      ACT_LOAD     = 3'd0,
      ACT_RUNTIME  = 3'd1,
      ACT_COMPUTE  = 3'd2,
      ACT_DEC_ALL  = 3'd3,
      ACT_DEC_HIGH = 3'd4,
      ACT_GAIN_LOW = 3'd5,
      ACT_QUERY    = 3'd6,
      ACT_NONE     = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      MODE_WORK     = 2'd0,
      MODE_DEADLINE = 2'd1,
      MODE_SCAN     = 2'd2
   } sum_mode_type;

   typedef enum logic [4:0] {
      CMD_IDLE,
      CMD_LATCH,
      CMD_ERROR,
      CMD_WRITE_PARAM,
      CMD_WRITE_RUN,
      CMD_ADJUST,
      CMD_MIN_INIT,
      CMD_MIN_STEP,
      CMD_ENTRY,
      CMD_HIGHER,
      CMD_DIV_START,
      CMD_TERM_MUL,
      CMD_TERM_ADD,
      CMD_SUM_END,
      CMD_UPDATE,
      CMD_SCAN_INIT,
      CMD_SCAN_LOAD,
      CMD_SCAN_MUL,
      CMD_SCAN_CHECK,
      CMD_SCAN_TEST,
      CMD_SCAN_STEP,
      CMD_SCAN_NEXT,
      CMD_FINISH,
      CMD_EMIT
   } cmd_type;

   typedef struct packed {
      action_type   act;
      logic         idx_bad;
      logic         idx_zero;
      logic         hit;
      sum_mode_type mode;
      logic         j_zero;
      logic         div_done;
      logic         p_zero;
      logic         over;
      logic         t_lt_di;
      logic         carry;
      logic         sj_zero;
      logic         min_done;
   } dp_status_type;

endpackage

// ===== rtl/core/fps_if.sv =====
// ----------------------------------------------------------------------------
// fps_if
// Valid/ready channels for request and response beats of the slack engine.
// ----------------------------------------------------------------------------
interface fps_req_if;
   import fps_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ACT_BITS-1:0]  action;
   logic [IDX_BITS-1:0]  task_index;
   logic [TICK_BITS-1:0] now_tick;
   logic [TICK_BITS-1:0] tick_amount;
   logic [TICK_BITS-1:0] period;
   logic [TICK_BITS-1:0] wcet;
   logic [TICK_BITS-1:0] rel_deadline;
   logic [TICK_BITS-1:0] wcrt;
   logic [TICK_BITS-1:0] release_time;
   logic [TICK_BITS-1:0] executed_time;
   logic [TICK_BITS-1:0] release_count;

   modport source (
      output valid, action, task_index, now_tick, tick_amount, period, wcet,
             rel_deadline, wcrt, release_time, executed_time, release_count,
      input  ready
   );
   modport sink (
      input  valid, action, task_index, now_tick, tick_amount, period, wcet,
             rel_deadline, wcrt, release_time, executed_time, release_count,
      output ready
   );
endinterface

interface fps_rsp_if;
   import fps_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [TICK_BITS-1:0] slack;
   logic [TICK_BITS-1:0]        slack_time;
   logic signed [TICK_BITS-1:0] available_slack;
   logic                        status;

   modport source (
      output valid, slack, slack_time, available_slack, status,
      input  ready
   );
   modport sink (
      input  valid, slack, slack_time, available_slack, status,
      output ready
   );
endinterface

// ===== rtl/core/fixed_priority_slack_engine_core.sv =====
// ----------------------------------------------------------------------------
// fixed_priority_slack_engine_core
// Fixed-priority slack-stealing engine with a 16-entry priority task table.
// ----------------------------------------------------------------------------
// One request beat runs one action on the task table (entry 0 is the highest
// priority) and returns exactly one response beat. The block works on one
// request at a time; a finished response waits in an output register, so the
// next request is taken while the previous response is still pending. Load,
// runtime, decrement and gain actions act on the table straight from decode,
// and a minimum query walks the task_count entries in turn. Computing slack
// for entry i uses the single iterative divider, which yields one quotient
// bit per cycle: each slack evaluation sums i+1 terms, and the computation
// makes two such sums plus one for every period multiple scanned below the
// absolute deadline, each multiple scan start costing another divide. Entry
// 0, or an entry resolved from the one above, needs no sum. The task_count
// register is reached at every address of the APB port and takes the low
// five bits of the write data; 0 reads back as 1 and a value above 16 as 16.
// ----------------------------------------------------------------------------
module fixed_priority_slack_engine_core (
   input  logic                              clock,
   input  logic                              reset,
   fps_req_if.sink                           req_bus,
   fps_rsp_if.source                         rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fps_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [fps_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [fps_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import fps_pkg::*;

   logic [COUNT_BITS-1:0] task_count_ff, task_count_in;
   logic [COUNT_BITS-1:0] wr_value;
   logic                  csr_write;
   cmd_type               cmd;
   dp_status_type         status;
   tick_type              slack_bits, avail_bits;

   // one register; every address of the port maps onto it
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && (csr_paddr[1:0] <= 2'd3);
   assign wr_value   = csr_pwdata[COUNT_BITS-1:0];
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(CSR_DATA_BITS-COUNT_BITS){1'b0}}, task_count_ff};

   // clamp the entry count to 1..MAX_TASKS
   always_comb begin
      task_count_in = task_count_ff;
      if (csr_write) begin
         priority if (wr_value == '0) begin
            task_count_in = COUNT_BITS'(1);
         end else if (wr_value > COUNT_BITS'(MAX_TASKS)) begin
            task_count_in = COUNT_BITS'(MAX_TASKS);
         end else begin
            task_count_in = wr_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= COUNT_BITS'(1);
      end else begin
         task_count_ff <= task_count_in;
      end
   end

   // sequencer: accepts beats, steps the datapath, holds response valid
   fps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // task table and arithmetic
   fps_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .task_count          (task_count_ff),
      .req_action          (req_bus.action),
      .req_task_index      (req_bus.task_index),
      .req_now_tick        (req_bus.now_tick),
      .req_tick_amount     (req_bus.tick_amount),
      .req_period          (req_bus.period),
      .req_wcet            (req_bus.wcet),
      .req_rel_deadline    (req_bus.rel_deadline),
      .req_wcrt            (req_bus.wcrt),
      .req_release_time    (req_bus.release_time),
      .req_executed_time   (req_bus.executed_time),
      .req_release_count   (req_bus.release_count),
      .status              (status),
      .rsp_slack           (slack_bits),
      .rsp_slack_time      (rsp_bus.slack_time),
      .rsp_available_slack (avail_bits),
      .rsp_status          (rsp_bus.status)
   );

   // slack values are two's complement on the response beat
   assign rsp_bus.slack           = $signed(slack_bits);
   assign rsp_bus.available_slack = $signed(avail_bits);

endmodule

// ===== rtl/core/fps_div.sv =====
// ----------------------------------------------------------------------------
// fps_div
// Restoring divider, one quotient bit per cycle, floor or ceiling result.
// ----------------------------------------------------------------------------
module fps_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          ceil_mode,
   input  logic [fps_pkg::TICK_BITS-1:0] num,
   input  logic [fps_pkg::TICK_BITS-1:0] den,
   output logic                          done,
   output logic [fps_pkg::TICK_BITS-1:0] quot
);
   import fps_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   tick_type                rem_ff;
   tick_type                quo_ff;
   tick_type                den_ff;
   logic                    ceil_ff;

   logic [TICK_BITS:0] rem_sh;
   logic [TICK_BITS:0] trial;
   logic               fits;

   assign rem_sh = {rem_ff, quo_ff[TICK_BITS-1]};
   assign trial  = rem_sh - {1'b0, den_ff};
   assign fits   = (rem_sh >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_BITS'(TICK_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quo_ff  <= num;
         den_ff  <= den;
         ceil_ff <= ceil_mode;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial[TICK_BITS-1:0] : rem_sh[TICK_BITS-1:0];
         quo_ff <= {quo_ff[TICK_BITS-2:0], fits};
      end
   end

   // zero divisor yields zero
   always_comb begin
      if (den_ff == '0) begin
         quot = '0;
      end else begin
         quot = quo_ff + {{(TICK_BITS-1){1'b0}}, (ceil_ff && (rem_ff != '0))};
      end
   end

   assign done = done_ff;

endmodule

// ===== rtl/core/fps_dp.sv =====
// ----------------------------------------------------------------------------
// fps_dp
// Datapath: task table, slack arithmetic, shared divider and multiplier.
// ----------------------------------------------------------------------------
module fps_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  fps_pkg::cmd_type               cmd,
   input  logic [fps_pkg::COUNT_BITS-1:0] task_count,
   input  logic [fps_pkg::ACT_BITS-1:0]   req_action,
   input  logic [fps_pkg::IDX_BITS-1:0]   req_task_index,
   input  logic [fps_pkg::TICK_BITS-1:0]  req_now_tick,
   input  logic [fps_pkg::TICK_BITS-1:0]  req_tick_amount,
   input  logic [fps_pkg::TICK_BITS-1:0]  req_period,
   input  logic [fps_pkg::TICK_BITS-1:0]  req_wcet,
   input  logic [fps_pkg::TICK_BITS-1:0]  req_rel_deadline,
   input  logic [fps_pkg::TICK_BITS-1:0]  req_wcrt,
   input  logic [fps_pkg::TICK_BITS-1:0]  req_release_time,
   input  logic [fps_pkg::TICK_BITS-1:0]  req_executed_time,
   input  logic [fps_pkg::TICK_BITS-1:0]  req_release_count,
   output fps_pkg::dp_status_type         status,
   output logic [fps_pkg::TICK_BITS-1:0]  rsp_slack,
   output logic [fps_pkg::TICK_BITS-1:0]  rsp_slack_time,
   output logic [fps_pkg::TICK_BITS-1:0]  rsp_available_slack,
   output logic                           rsp_status
);
   import fps_pkg::*;

   // task table
   tick_type period_ff    [MAX_TASKS];
   tick_type wcet_ff      [MAX_TASKS];
   tick_type rel_dl_ff    [MAX_TASKS];
   tick_type wcrt_ff      [MAX_TASKS];
   tick_type release_ff   [MAX_TASKS];
   tick_type executed_ff  [MAX_TASKS];
   tick_type rel_count_ff [MAX_TASKS];
   tick_type abs_dl_ff    [MAX_TASKS];
   tick_type slack_ff     [MAX_TASKS];
   tick_type slack_time_ff[MAX_TASKS];

   // latched request
   action_type          act_ff;
   logic [IDX_BITS-1:0] idx_ff;
   tick_type            tc_ff;
   tick_type            tk_ff;
   tick_type            in_period_ff, in_wcet_ff, in_rel_dl_ff, in_wcrt_ff;
   tick_type            in_release_ff, in_executed_ff, in_rel_count_ff;

   // working registers
   tick_type              di_ff, ivl_ff, wi_ff, kmax_ff, tmax_ff, wc_ff, w_ff;
   tick_type              t_ff, num_ff, k2_ff, c_ff, m_ff;
   logic [2*TICK_BITS-1:0] prod_ff;
   sum_mode_type          mode_ff;
   logic [IDX_BITS-1:0]   j_ff, sj_ff;
   logic [COUNT_BITS-1:0] k_ff;

   // result and output registers
   tick_type res_slack_ff, res_time_ff, res_avail_ff;
   logic     res_status_ff;
   tick_type out_slack_ff, out_time_ff, out_avail_ff;
   logic     out_status_ff;

   logic [IDX_BITS-1:0] rd_addr;
   tick_type            rd_period, rd_wcet, rd_rel_dl, rd_wcrt, rd_release;
   tick_type            rd_executed, rd_rel_count, rd_abs_dl, rd_slack, rd_slack_time;

   tick_type            di_calc, xi_calc, hd;
   logic                hd_in_window, hit;
   logic                div_start, div_ceil, div_done;
   tick_type            div_num, div_quot;
   tick_type            mul_b;
   logic [TICK_BITS:0]  step_sum;

   // one read port, address chosen by the current step
   always_comb begin
      unique case (cmd)
         CMD_HIGHER:                                 rd_addr = idx_ff - 1'b1;
         CMD_DIV_START, CMD_TERM_MUL:                rd_addr = j_ff;
         CMD_SCAN_LOAD, CMD_SCAN_MUL, CMD_SCAN_STEP: rd_addr = sj_ff;
         CMD_MIN_STEP:                               rd_addr = k_ff[IDX_BITS-1:0];
         CMD_MIN_INIT:                               rd_addr = '0;
         default:                                    rd_addr = idx_ff;
      endcase
   end

   assign rd_period     = period_ff[rd_addr];
   assign rd_wcet       = wcet_ff[rd_addr];
   assign rd_rel_dl     = rel_dl_ff[rd_addr];
   assign rd_wcrt       = wcrt_ff[rd_addr];
   assign rd_release    = release_ff[rd_addr];
   assign rd_executed   = executed_ff[rd_addr];
   assign rd_rel_count  = rel_count_ff[rd_addr];
   assign rd_abs_dl     = abs_dl_ff[rd_addr];
   assign rd_slack      = slack_ff[rd_addr];
   assign rd_slack_time = slack_time_ff[rd_addr];

   assign xi_calc      = (tc_ff != '0) ? rd_release : '0;
   assign di_calc      = xi_calc + rd_rel_dl;
   assign hd           = rd_abs_dl + rd_wcet;
   assign hit          = (hd >= di_ff) && (di_ff >= rd_slack_time);
   assign hd_in_window = (hd >= ivl_ff) && (hd <= di_ff);
   assign step_sum     = {1'b0, t_ff} + {1'b0, rd_period};

   assign div_start = (cmd == CMD_DIV_START) || ((cmd == CMD_SCAN_LOAD) && (rd_period != '0));
   assign div_num   = (cmd == CMD_SCAN_LOAD) ? ivl_ff : num_ff;
   assign div_ceil  = (cmd == CMD_SCAN_LOAD) || (mode_ff != MODE_WORK);
   assign mul_b     = (cmd == CMD_SCAN_MUL) ? rd_period : rd_wcet;

   fps_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .ceil_mode (div_ceil),
      .num       (div_num),
      .den       (rd_period),
      .done      (div_done),
      .quot      (div_quot)
   );

   always_comb begin
      status          = '0;
      status.act      = act_ff;
      status.idx_bad  = ({1'b0, idx_ff} >= task_count);
      status.idx_zero = (idx_ff == '0);
      status.hit      = hit;
      status.mode     = mode_ff;
      status.j_zero   = (j_ff == '0);
      status.div_done = div_done;
      status.p_zero   = (rd_period == '0);
      status.over     = (prod_ff[2*TICK_BITS-1:TICK_BITS] != '0);
      status.t_lt_di  = (t_ff < di_ff);
      status.carry    = step_sum[TICK_BITS];
      status.sj_zero  = (sj_ff == '0);
      status.min_done = (k_ff >= task_count);
   end

   // table writes
   always_ff @(posedge clock) begin
      unique case (cmd)
         CMD_WRITE_PARAM: begin
            period_ff[idx_ff] <= in_period_ff;
            wcet_ff[idx_ff]   <= in_wcet_ff;
            rel_dl_ff[idx_ff] <= in_rel_dl_ff;
            wcrt_ff[idx_ff]   <= in_wcrt_ff;
         end
         CMD_WRITE_RUN: begin
            release_ff[idx_ff]   <= in_release_ff;
            executed_ff[idx_ff]  <= in_executed_ff;
            rel_count_ff[idx_ff] <= in_rel_count_ff;
         end
         CMD_ADJUST: begin
            for (int k = 0; k < MAX_TASKS; k++) begin
               if ((act_ff == ACT_DEC_ALL) && (COUNT_BITS'(k) < task_count)
                   && !slack_ff[k][TICK_BITS-1] && (slack_ff[k] != '0)) begin
                  slack_ff[k] <= slack_ff[k] - tk_ff;
               end else if ((act_ff == ACT_DEC_HIGH) && (IDX_BITS'(k) < idx_ff)
                   && !slack_ff[k][TICK_BITS-1] && (slack_ff[k] != '0)) begin
                  slack_ff[k] <= slack_ff[k] + ~tk_ff + 1'b1;
               end else if ((act_ff == ACT_GAIN_LOW) && (IDX_BITS'(k) > idx_ff)
                   && (COUNT_BITS'(k) < task_count)) begin
                  slack_ff[k] <= slack_ff[k] + tk_ff;
               end
            end
         end
         CMD_ENTRY: begin
            abs_dl_ff[idx_ff] <= di_calc;
            if (idx_ff == '0) begin
               slack_ff[idx_ff]      <= di_calc - tc_ff - rd_wcet;
               slack_time_ff[idx_ff] <= di_calc;
            end
         end
         CMD_HIGHER: begin
            if (hit) begin
               slack_ff[idx_ff]      <= rd_slack - wi_ff;
               slack_time_ff[idx_ff] <= rd_slack_time;
            end
         end
         CMD_FINISH: begin
            slack_ff[idx_ff]      <= kmax_ff;
            slack_time_ff[idx_ff] <= tmax_ff;
         end
         default: begin
         end
      endcase
   end

   // working registers and results
   always_ff @(posedge clock) begin
      unique case (cmd)
         CMD_LATCH: begin
            act_ff          <= action_type'(req_action);
            idx_ff          <= req_task_index;
            tc_ff           <= req_now_tick;
            tk_ff           <= req_tick_amount;
            in_period_ff    <= req_period;
            in_wcet_ff      <= req_wcet;
            in_rel_dl_ff    <= req_rel_deadline;
            in_wcrt_ff      <= req_wcrt;
            in_release_ff   <= req_release_time;
            in_executed_ff  <= req_executed_time;
            in_rel_count_ff <= req_release_count;
            res_slack_ff    <= '0;
            res_time_ff     <= '0;
            res_avail_ff    <= '0;
            res_status_ff   <= 1'b0;
         end
         CMD_ERROR: begin
            res_status_ff <= 1'b1;
         end
         CMD_MIN_INIT: begin
            m_ff <= rd_slack;
            k_ff <= COUNT_BITS'(1);
         end
         CMD_MIN_STEP: begin
            if (k_ff < task_count) begin
               if ($signed(rd_slack) < $signed(m_ff)) begin
                  m_ff <= rd_slack;
               end
               k_ff <= k_ff + 1'b1;
            end else begin
               res_avail_ff <= m_ff;
            end
         end
         CMD_ENTRY: begin
            di_ff  <= di_calc;
            wi_ff  <= rd_wcet;
            ivl_ff <= di_calc - rd_wcrt + rd_wcet;
            if (idx_ff == '0) begin
               res_slack_ff <= di_calc - tc_ff - rd_wcet;
               res_time_ff  <= di_calc;
            end
         end
         CMD_HIGHER: begin
            // corollaries from the entry just above; set up the workload sum
            if (hit) begin
               res_slack_ff <= rd_slack - wi_ff;
               res_time_ff  <= rd_slack_time;
            end else if (hd_in_window) begin
               ivl_ff  <= hd;
               kmax_ff <= rd_slack - wi_ff;
               tmax_ff <= rd_slack_time;
            end else begin
               kmax_ff <= '0;
               tmax_ff <= '1;
            end
            mode_ff <= MODE_WORK;
            num_ff  <= tc_ff;
            w_ff    <= '0;
            j_ff    <= idx_ff;
         end
         CMD_TERM_MUL: begin
            prod_ff <= {{TICK_BITS{1'b0}}, div_quot} * {{TICK_BITS{1'b0}}, mul_b};
            if ((mode_ff == MODE_WORK) && (tc_ff != '0)
                && !((rd_wcet == rd_executed) && (div_quot >= rd_rel_count))) begin
               c_ff <= rd_wcet;
            end else begin
               c_ff <= '0;
            end
         end
         CMD_TERM_ADD: begin
            w_ff <= w_ff + prod_ff[TICK_BITS-1:0] + c_ff;
            j_ff <= j_ff - 1'b1;
         end
         CMD_SUM_END: begin
            if (mode_ff == MODE_WORK) begin
               wc_ff   <= w_ff;
               t_ff    <= di_ff;
               num_ff  <= di_ff;
               mode_ff <= MODE_DEADLINE;
               w_ff    <= '0;
               j_ff    <= idx_ff;
            end else begin
               k2_ff <= t_ff - tc_ff - w_ff + wc_ff;
            end
         end
         CMD_UPDATE: begin
            if (mode_ff == MODE_DEADLINE) begin
               if (!($signed(k2_ff) < $signed(kmax_ff))) begin
                  kmax_ff <= k2_ff;
                  if (k2_ff != kmax_ff) begin
                     tmax_ff <= di_ff;
                  end else if (tmax_ff > di_ff) begin
                     tmax_ff <= di_ff;
                  end
               end
            end else begin
               if ($signed(kmax_ff) < $signed(k2_ff)) begin
                  kmax_ff <= k2_ff;
                  tmax_ff <= t_ff;
               end else if ((k2_ff == kmax_ff) && (t_ff < tmax_ff)) begin
                  tmax_ff <= t_ff;
               end
            end
         end
         CMD_SCAN_INIT: begin
            sj_ff <= idx_ff - 1'b1;
         end
         CMD_SCAN_MUL: begin
            prod_ff <= {{TICK_BITS{1'b0}}, div_quot} * {{TICK_BITS{1'b0}}, mul_b};
         end
         CMD_SCAN_CHECK: begin
            if (prod_ff[2*TICK_BITS-1:TICK_BITS] == '0) begin
               t_ff <= prod_ff[TICK_BITS-1:0];
            end
         end
         CMD_SCAN_TEST: begin
            if (t_ff < di_ff) begin
               mode_ff <= MODE_SCAN;
               num_ff  <= t_ff;
               w_ff    <= '0;
               j_ff    <= idx_ff;
            end
         end
         CMD_SCAN_STEP: begin
            if (!step_sum[TICK_BITS]) begin
               t_ff <= step_sum[TICK_BITS-1:0];
            end
         end
         CMD_SCAN_NEXT: begin
            sj_ff <= sj_ff - 1'b1;
         end
         CMD_FINISH: begin
            res_slack_ff <= kmax_ff;
            res_time_ff  <= tmax_ff;
         end
         CMD_EMIT: begin
            out_slack_ff  <= res_slack_ff;
            out_time_ff   <= res_time_ff;
            out_avail_ff  <= res_avail_ff;
            out_status_ff <= res_status_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_slack           = out_slack_ff;
   assign rsp_slack_time      = out_time_ff;
   assign rsp_available_slack = out_avail_ff;
   assign rsp_status          = out_status_ff;

endmodule

// ===== rtl/core/fps_ctrl.sv =====
// ----------------------------------------------------------------------------
// fps_ctrl
// Sequencer for the slack engine: decodes actions and steps the datapath.
// ----------------------------------------------------------------------------
module fps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  fps_pkg::dp_status_type status,
   output fps_pkg::cmd_type       cmd
);
   import fps_pkg::*;

   typedef enum logic [19:0] {
      S_IDLE       = 20'h00001,
      S_DECODE     = 20'h00002,
      S_HIGHER     = 20'h00004,
      S_DIV_START  = 20'h00008,
      S_DIV_WAIT   = 20'h00010,
      S_MUL        = 20'h00020,
      S_ADD        = 20'h00040,
      S_SUM_END    = 20'h00080,
      S_UPDATE     = 20'h00100,
      S_SCAN_INIT  = 20'h00200,
      S_SCAN_LOAD  = 20'h00400,
      S_SCAN_WAIT  = 20'h00800,
      S_SCAN_MUL   = 20'h01000,
      S_SCAN_CHECK = 20'h02000,
      S_SCAN_TEST  = 20'h04000,
      S_SCAN_STEP  = 20'h08000,
      S_SCAN_NEXT  = 20'h10000,
      S_FINISH     = 20'h20000,
      S_MIN        = 20'h40000,
      S_RESULT     = 20'h80000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      needs_index;
   logic      slot_free;

   assign needs_index = (status.act == ACT_LOAD) || (status.act == ACT_RUNTIME)
                     || (status.act == ACT_COMPUTE) || (status.act == ACT_DEC_HIGH)
                     || (status.act == ACT_GAIN_LOW);
   assign slot_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = CMD_IDLE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (needs_index && status.idx_bad) begin
               cmd      = CMD_ERROR;
               state_in = S_RESULT;
            end else begin
               unique case (status.act)
                  ACT_LOAD: begin
                     cmd      = CMD_WRITE_PARAM;
                     state_in = S_RESULT;
                  end
                  ACT_RUNTIME: begin
                     cmd      = CMD_WRITE_RUN;
                     state_in = S_RESULT;
                  end
                  ACT_COMPUTE: begin
                     cmd      = CMD_ENTRY;
                     state_in = status.idx_zero ? S_RESULT : S_HIGHER;
                  end
                  ACT_DEC_ALL, ACT_DEC_HIGH, ACT_GAIN_LOW: begin
                     cmd      = CMD_ADJUST;
                     state_in = S_RESULT;
                  end
                  ACT_QUERY: begin
                     cmd      = CMD_MIN_INIT;
                     state_in = S_MIN;
                  end
                  default: begin
                     state_in = S_RESULT;
                  end
               endcase
            end
         end
         S_HIGHER: begin
            cmd      = CMD_HIGHER;
            state_in = status.hit ? S_RESULT : S_DIV_START;
         end
         S_DIV_START: begin
            cmd      = CMD_DIV_START;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd      = CMD_TERM_MUL;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd      = CMD_TERM_ADD;
            state_in = status.j_zero ? S_SUM_END : S_DIV_START;
         end
         S_SUM_END: begin
            cmd      = CMD_SUM_END;
            state_in = (status.mode == MODE_WORK) ? S_DIV_START : S_UPDATE;
         end
         S_UPDATE: begin
            cmd      = CMD_UPDATE;
            state_in = (status.mode == MODE_DEADLINE) ? S_SCAN_INIT : S_SCAN_STEP;
         end
         S_SCAN_INIT: begin
            cmd      = CMD_SCAN_INIT;
            state_in = S_SCAN_LOAD;
         end
         S_SCAN_LOAD: begin
            cmd      = CMD_SCAN_LOAD;
            state_in = status.p_zero ? S_SCAN_NEXT : S_SCAN_WAIT;
         end
         S_SCAN_WAIT: begin
            if (status.div_done) begin
               state_in = S_SCAN_MUL;
            end
         end
         S_SCAN_MUL: begin
            cmd      = CMD_SCAN_MUL;
            state_in = S_SCAN_CHECK;
         end
         S_SCAN_CHECK: begin
            cmd      = CMD_SCAN_CHECK;
            state_in = status.over ? S_SCAN_NEXT : S_SCAN_TEST;
         end
         S_SCAN_TEST: begin
            cmd      = CMD_SCAN_TEST;
            state_in = status.t_lt_di ? S_DIV_START : S_SCAN_NEXT;
         end
         S_SCAN_STEP: begin
            cmd      = CMD_SCAN_STEP;
            state_in = status.carry ? S_SCAN_NEXT : S_SCAN_TEST;
         end
         S_SCAN_NEXT: begin
            cmd      = CMD_SCAN_NEXT;
            state_in = status.sj_zero ? S_FINISH : S_SCAN_LOAD;
         end
         S_FINISH: begin
            cmd      = CMD_FINISH;
            state_in = S_RESULT;
         end
         S_MIN: begin
            cmd = CMD_MIN_STEP;
            if (status.min_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (slot_free) begin
               cmd          = CMD_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
